// ----- hw/rtl/fbsc_pkg.sv -----
package fbsc_pkg;

    localparam int DEB_W = 10;
    localparam int TICK_W = 16;
    localparam int LVL_W = 3;
    localparam int DUTY_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEB_W-1:0]  DEB_MAX = '1;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 10'd30;
    localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'd3000;
    localparam logic [TICK_W-1:0] BLINK_ON_RST = 16'd150;
    localparam logic [TICK_W-1:0] BLINK_GAP_RST = 16'd150;
    localparam logic [TICK_W-1:0] BLINK_PERIOD_RST = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_LONG_PRESS   = 3'd1,
        REG_BLINK_ON     = 3'd2,
        REG_BLINK_GAP    = 3'd3,
        REG_BLINK_PERIOD = 3'd4,
        REG_DUTY_UNINV   = 3'd5,
        REG_SPIN_CW      = 3'd6
    } cfg_reg_t;

endpackage

// ----- hw/rtl/fbsc_if.sv -----
interface fbsc_btn_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink   (input valid, input button_level, output ready);
endinterface

interface fbsc_res_if import fbsc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_duty;
    logic              direction_level;
    logic              led_lit;
    logic              fan_running;
    logic [LVL_W-1:0]  speed_level;

    modport source (output valid, output pwm_duty, output direction_level, output led_lit,
                    output fan_running, output speed_level, input ready);
    modport sink   (input valid, input pwm_duty, input direction_level, input led_lit,
                    input fan_running, input speed_level, output ready);
endinterface

interface fbsc_cfg_if import fbsc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/fan_button_speed_controller_core.sv -----
// An accepted tick is held in the tick register, then processed into the result register that drives res.
// Throughput: one tick per cycle; the tick register and the result register
// form a two-entry pipeline, so btn stays ready while res is taken every cycle.
// The whole debounce, press and blink update for a tick fits between those two.
// Reset (rst_n low, asynchronous): fan off, level 0, button taken as released,
// all counters cleared, timing registers back to their power-on values.
module fan_button_speed_controller_core
    import fbsc_pkg::*;
#(
    parameter int NUM_LEVELS = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    fbsc_btn_if.sink      btn,
    fbsc_res_if.source    res,
    fbsc_cfg_if.sink      cfg
);

    localparam int BD_W = $clog2(NUM_LEVELS + 1);
    localparam int SPAN = (NUM_LEVELS > 1) ? NUM_LEVELS - 1 : 1;

    // Duty per level, both polarities, worked out at elaboration
    logic [DUTY_W-1:0] duty_up_tab  [2**LVL_W];
    logic [DUTY_W-1:0] duty_inv_tab [2**LVL_W];

    for (genvar g = 0; g < 2**LVL_W; g++) begin : g_lvl
        localparam int PCT = (NUM_LEVELS <= 1) ? 15 :
                             (g > SPAN) ? 100 : 15 + (170 * g + SPAN) / (2 * SPAN);
        localparam int DUP = PCT * 255 / 100;
        localparam int DINV = (100 - PCT) * 255 / 100;
        assign duty_up_tab[g]  = DUTY_W'(DUP);
        assign duty_inv_tab[g] = DUTY_W'(DINV);
    end

    // Configuration registers
    logic [DEB_W-1:0]  debounce_reg;
    logic [TICK_W-1:0] long_press_reg;
    logic [TICK_W-1:0] blink_on_reg;
    logic [TICK_W-1:0] blink_gap_reg;
    logic [TICK_W-1:0] blink_period_reg;
    logic              duty_uninv_reg;
    logic              spin_cw_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RST;
            long_press_reg   <= LONG_PRESS_RST;
            blink_on_reg     <= BLINK_ON_RST;
            blink_gap_reg    <= BLINK_GAP_RST;
            blink_period_reg <= BLINK_PERIOD_RST;
            duty_uninv_reg   <= 1'b1;
            spin_cw_reg      <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_DEBOUNCE:     debounce_reg     <= cfg.data[DEB_W-1:0];
                REG_LONG_PRESS:   long_press_reg   <= cfg.data[TICK_W-1:0];
                REG_BLINK_ON:     blink_on_reg     <= cfg.data[TICK_W-1:0];
                REG_BLINK_GAP:    blink_gap_reg    <= cfg.data[TICK_W-1:0];
                REG_BLINK_PERIOD: blink_period_reg <= cfg.data[TICK_W-1:0];
                REG_DUTY_UNINV:   duty_uninv_reg   <= cfg.data[0];
                REG_SPIN_CW:      spin_cw_reg      <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    // Tick register and result register handshake
    logic tick_valid_reg;
    logic tick_level_reg;
    logic out_valid_reg;
    logic fire;

    assign fire      = tick_valid_reg && (!out_valid_reg || res.ready);
    assign btn.ready = !tick_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (btn.ready)
            begin
                tick_valid_reg <= btn.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (btn.valid && btn.ready)
        begin
            tick_level_reg <= btn.button_level;
        end
    end

    // Controller state
    logic              running_reg, running_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic              prev_raw_reg, prev_raw_next;
    logic [DEB_W-1:0]  stable_reg, stable_next;
    logic              deb_pressed_reg, deb_pressed_next;
    logic [TICK_W-1:0] hold_reg, hold_next;
    logic              long_fired_reg, long_fired_next;
    logic [TICK_W-1:0] period_reg, period_next;
    logic [TICK_W-1:0] toggle_reg, toggle_next;
    logic [BD_W-1:0]   blinks_reg, blinks_next;
    logic              led_reg, led_next;
    logic              restart_reg, restart_next;

    logic [LVL_W:0]    level_inc;
    logic [LVL_W:0]    blinks_req;
    logic              pressed_now;
    logic [DUTY_W-1:0] duty_next;

    always_comb
    begin
        running_next     = running_reg;
        level_next       = level_reg;
        stable_next      = stable_reg;
        deb_pressed_next = deb_pressed_reg;
        hold_next        = hold_reg;
        long_fired_next  = long_fired_reg;
        period_next      = period_reg;
        toggle_next      = toggle_reg;
        blinks_next      = blinks_reg;
        led_next         = led_reg;
        restart_next     = restart_reg;
        prev_raw_next    = tick_level_reg;
        pressed_now      = !tick_level_reg;
        level_inc        = {1'b0, level_reg} + 1'b1;

        // Debounce
        if (deb_pressed_reg && hold_reg != TICK_MAX)
        begin
            hold_next = hold_reg + 1'b1;
        end
        if (tick_level_reg != prev_raw_reg)
        begin
            stable_next = '0;
        end
        else if (stable_reg != DEB_MAX)
        begin
            stable_next = stable_reg + 1'b1;
        end

        // Press and release
        if (stable_next > debounce_reg && pressed_now != deb_pressed_reg)
        begin
            deb_pressed_next = pressed_now;
            if (pressed_now)
            begin
                hold_next       = '0;
                long_fired_next = 1'b0;
            end
            else if (!long_fired_reg && hold_next < long_press_reg && running_reg)
            begin
                level_next   = (level_inc >= (LVL_W+1)'(NUM_LEVELS)) ? '0
                                                                      : level_inc[LVL_W-1:0];
                restart_next = 1'b1;
            end
        end
        if (deb_pressed_next && !long_fired_next && hold_next >= long_press_reg)
        begin
            long_fired_next = 1'b1;
            running_next    = !running_reg;
            if (!running_reg)
            begin
                level_next = '0;
            end
            restart_next = 1'b1;
        end

        // Blink burst
        blinks_req = {1'b0, level_next} + 1'b1;
        if (!running_next)
        begin
            led_next     = 1'b0;
            restart_next = 1'b1;
        end
        else
        begin
            if (restart_next)
            begin
                period_next  = '0;
                toggle_next  = '0;
                blinks_next  = '0;
                led_next     = 1'b0;
                restart_next = 1'b0;
            end
            else
            begin
                if (period_reg != TICK_MAX)
                begin
                    period_next = period_reg + 1'b1;
                end
                if (toggle_reg != TICK_MAX)
                begin
                    toggle_next = toggle_reg + 1'b1;
                end
            end
            if ((LVL_W+1)'(blinks_next) < blinks_req)
            begin
                if (!led_next && toggle_next >= blink_gap_reg)
                begin
                    led_next    = 1'b1;
                    toggle_next = '0;
                end
                else if (led_next && toggle_next >= blink_on_reg)
                begin
                    led_next    = 1'b0;
                    blinks_next = blinks_next + 1'b1;
                    toggle_next = '0;
                end
            end
            else if (period_next >= blink_period_reg)
            begin
                period_next = '0;
                blinks_next = '0;
            end
        end

        // Duty: off is 0 percent
        if (!running_next)
        begin
            duty_next = duty_uninv_reg ? '0 : '1;
        end
        else
        begin
            duty_next = duty_uninv_reg ? duty_up_tab[level_next] : duty_inv_tab[level_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            level_reg       <= '0;
            prev_raw_reg    <= 1'b1;
            stable_reg      <= '0;
            deb_pressed_reg <= 1'b0;
            hold_reg        <= '0;
            long_fired_reg  <= 1'b0;
            period_reg      <= '0;
            toggle_reg      <= '0;
            blinks_reg      <= '0;
            led_reg         <= 1'b0;
            restart_reg     <= 1'b1;
        end
        else if (fire)
        begin
            running_reg     <= running_next;
            level_reg       <= level_next;
            prev_raw_reg    <= prev_raw_next;
            stable_reg      <= stable_next;
            deb_pressed_reg <= deb_pressed_next;
            hold_reg        <= hold_next;
            long_fired_reg  <= long_fired_next;
            period_reg      <= period_next;
            toggle_reg      <= toggle_next;
            blinks_reg      <= blinks_next;
            led_reg         <= led_next;
            restart_reg     <= restart_next;
        end
    end

    // Result register
    logic [DUTY_W-1:0] duty_reg;
    logic              dir_reg;
    logic              led_lit_reg;
    logic              run_out_reg;
    logic [LVL_W-1:0]  level_out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            duty_reg      <= duty_next;
            dir_reg       <= !spin_cw_reg;
            led_lit_reg   <= running_next && led_next;
            run_out_reg   <= running_next;
            level_out_reg <= level_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.pwm_duty        = duty_reg;
    assign res.direction_level = dir_reg;
    assign res.led_lit         = led_lit_reg;
    assign res.fan_running     = run_out_reg;
    assign res.speed_level     = level_out_reg;

`ifndef SYNTH
    a_led_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!led_lit_reg || run_out_reg))
        else $error("LED lit while fan stopped");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (LVL_W+1)'(level_reg) < (LVL_W+1)'(NUM_LEVELS))
        else $error("speed level out of range");

    a_blinks_range: assert property (@(posedge clk) disable iff (!rst_n)
        (LVL_W+1)'(blinks_reg) <= (LVL_W+1)'(level_reg) + 1'b1 || restart_reg)
        else $error("blink count past burst length");

    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed tick produced no result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> $stable(duty_reg) && $stable(level_out_reg))
        else $error("result changed while stalled");
`endif

endmodule
